[rtl/core/camera_view_projection_macros.svh]
// assertion macros for the camera view projection block
`ifndef CAMERA_VIEW_PROJECTION_MACROS_SVH
`define CAMERA_VIEW_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS

`define CVP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cvp check failed");

`define CVP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cvp check failed");

`else

`define CVP_ASSERT_SAME(lbl, ante, cons)
`define CVP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/core/cvp_pkg.sv]
package cvp_pkg;

	localparam int TrigFrac   = 14;
	localparam int RotW       = 37;
	localparam int NumW       = 48;
	localparam int MagW       = 63;
	localparam int DenW       = 37;
	localparam int DivStages  = MagW;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = 2;
	localparam int QueueCntW  = 3;

	localparam logic [2:0] REG_CAM_X     = 3'd0;
	localparam logic [2:0] REG_CAM_Y     = 3'd1;
	localparam logic [2:0] REG_CAM_Z     = 3'd2;
	localparam logic [2:0] REG_COS_YAW   = 3'd3;
	localparam logic [2:0] REG_SIN_YAW   = 3'd4;
	localparam logic [2:0] REG_COS_PITCH = 3'd5;
	localparam logic [2:0] REG_SIN_PITCH = 3'd6;
	localparam logic [2:0] REG_FOCAL     = 3'd7;

	localparam logic signed [64:0] SCREEN_X_OFS = 65'sd62914560;
	localparam logic signed [64:0] SCREEN_Y_OFS = 65'sd35389440;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic signed [15:0] cos_yaw;
		logic signed [15:0] sin_yaw;
		logic signed [15:0] cos_pitch;
		logic signed [15:0] sin_pitch;
		logic [9:0]         focal;
	} cvp_cfg_t;

	typedef struct packed {
		logic signed [RotW-1:0] rx;
		logic signed [RotW-1:0] ry;
		logic signed [RotW-1:0] rz;
	} cvp_view_t;

	typedef struct packed {
		logic [QueueCntW-1:0] cnt;
		logic                 full;
		logic                 empty;
	} cvp_qstat_t;

	typedef struct packed {
		logic        sx;
		logic        sy;
		logic [31:0] dep;
	} cvp_sb_t;

	function automatic logic [31:0] sat32(input logic signed [64:0] v);
		logic [31:0] r;
		if (v > 65'sd2147483647) begin
			r = 32'h7fffffff;
		end else if (v < -65'sd2147483648) begin
			r = 32'h80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/cvp_front.sv]
module cvp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  cvp_pkg::cvp_cfg_t   cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  px,
	input  logic signed [31:0]  py,
	input  logic signed [31:0]  pz,
	input  logic                q_full,
	output logic                push,
	output cvp_pkg::cvp_view_t  view
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [48:0] xc_s2, zs_s2, xs_s2, zc_s2;
	logic signed [32:0] dy_s2;
	logic signed [cvp_pkg::RotW-1:0] rx_s3, w_s3;
	logic signed [32:0] dy_s3;
	logic signed [52:0] wc_s4, ys_s4, yc_s4, ws_s4;
	logic signed [cvp_pkg::RotW-1:0] rx_s4;
	logic signed [cvp_pkg::RotW-1:0] rx_s5, ry_s5, rz_s5;

	logic signed [49:0] rx_sum, w_sum;
	logic signed [53:0] rz_sum, ry_sum;

	assign en       = !q_full;
	assign in_ready = en;

	always_comb begin
		rx_sum = 50'(xc_s2) - 50'(zs_s2);
		w_sum  = 50'(xs_s2) + 50'(zc_s2);
		rz_sum = 54'(wc_s4) + 54'(ys_s4);
		ry_sum = 54'(yc_s4) - 54'(ws_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(px) - 33'(cfg.cam_x);
			dy_s1 <= 33'(py) - 33'(cfg.cam_y);
			dz_s1 <= 33'(pz) - 33'(cfg.cam_z);

			xc_s2 <= dx_s1 * cfg.cos_yaw;
			zs_s2 <= dz_s1 * cfg.sin_yaw;
			xs_s2 <= dx_s1 * cfg.sin_yaw;
			zc_s2 <= dz_s1 * cfg.cos_yaw;
			dy_s2 <= dy_s1;

			rx_s3 <= cvp_pkg::RotW'(rx_sum >>> cvp_pkg::TrigFrac);
			w_s3  <= cvp_pkg::RotW'(w_sum >>> cvp_pkg::TrigFrac);
			dy_s3 <= dy_s2;

			wc_s4 <= w_s3 * cfg.cos_pitch;
			ys_s4 <= 53'(dy_s3) * cfg.sin_pitch;
			yc_s4 <= 53'(dy_s3) * cfg.cos_pitch;
			ws_s4 <= w_s3 * cfg.sin_pitch;
			rx_s4 <= rx_s3;

			rx_s5 <= rx_s4;
			rz_s5 <= cvp_pkg::RotW'(rz_sum >>> cvp_pkg::TrigFrac);
			ry_s5 <= cvp_pkg::RotW'(ry_sum >>> cvp_pkg::TrigFrac);
		end
	end

	assign push    = v_s5 && en;
	assign view.rx = rx_s5;
	assign view.ry = ry_s5;
	assign view.rz = rz_s5;

endmodule

[rtl/core/cvp_queue.sv]
module cvp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cvp_pkg::cvp_view_t  wr_data,
	input  logic                pop,
	output cvp_pkg::cvp_view_t  rd_data,
	output cvp_pkg::cvp_qstat_t stat
);

	cvp_pkg::cvp_view_t mem_q [cvp_pkg::QueueDepth];
	logic [cvp_pkg::QueuePtrW-1:0] wr_q, rd_q;
	logic [cvp_pkg::QueueCntW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	assign rd_data    = mem_q[rd_q];
	assign stat.cnt   = cnt_q;
	assign stat.full  = (cnt_q == cvp_pkg::QueueCntW'(cvp_pkg::QueueDepth));
	assign stat.empty = (cnt_q == '0);

endmodule

[rtl/core/cvp_div.sv]
module cvp_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [cvp_pkg::MagW-1:0]    num,
	input  logic [cvp_pkg::DenW-1:0]    den,
	output logic [cvp_pkg::MagW-1:0]    quo
);

	localparam int N  = cvp_pkg::DivStages;
	localparam int MW = cvp_pkg::MagW;
	localparam int DW = cvp_pkg::DenW;

	logic [DW-1:0] rem_sd [N];
	logic [MW-1:0] nq_sd  [N];
	logic [DW-1:0] den_sd [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [DW-1:0] rem_in, den_in;
		logic [MW-1:0] nq_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_sd[k-1];
			assign nq_in  = nq_sd[k-1];
			assign den_in = den_sd[k-1];
		end

		assign trial = {rem_in, nq_in[MW-1]};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
				nq_sd[k]  <= {nq_in[MW-2:0], ge};
				den_sd[k] <= den_in;
			end
		end
	end

	assign quo = nq_sd[N-1];

endmodule

[rtl/core/cvp_back.sv]
module cvp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [9:0]          focal,
	input  logic                q_empty,
	input  cvp_pkg::cvp_view_t  head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         screen_x,
	output logic [31:0]         screen_y,
	output logic [31:0]         view_depth
);

	localparam int N = cvp_pkg::DivStages;

	logic en;
	logic v_b1, v_b2, v_b3, out_valid_q;
	logic [N-1:0] v_sd;

	logic signed [cvp_pkg::NumW-1:0] nx_b1, ny_b1;
	logic [cvp_pkg::DenW-1:0] zc_b1, zc_b2;
	logic [31:0] dep_b1;

	logic [cvp_pkg::MagW-1:0] mx_b2, my_b2;
	cvp_pkg::cvp_sb_t sb_b2;
	cvp_pkg::cvp_sb_t sb_sd [N];

	logic [cvp_pkg::MagW-1:0] qx, qy;
	logic signed [64:0] qx_b3, qy_b3;
	logic [31:0] dep_b3;

	logic signed [cvp_pkg::NumW-1:0] ax, ay;
	logic [31:0] sx_q, sy_q, dep_q;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_empty;

	always_comb begin
		ax = nx_b1[cvp_pkg::NumW-1] ? -nx_b1 : nx_b1;
		ay = ny_b1[cvp_pkg::NumW-1] ? -ny_b1 : ny_b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1        <= 1'b0;
			v_b2        <= 1'b0;
			v_sd        <= '0;
			v_b3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_b1        <= !q_empty;
			v_b2        <= v_b1;
			v_sd        <= {v_sd[N-2:0], v_b2};
			v_b3        <= v_sd[N-1];
			out_valid_q <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_b1  <= cvp_pkg::NumW'(head.rx) * $signed({1'b0, focal});
			ny_b1  <= cvp_pkg::NumW'(head.ry) * $signed({1'b0, focal});
			zc_b1  <= (head.rz < 37'sd1) ? cvp_pkg::DenW'(1) : cvp_pkg::DenW'(head.rz);
			dep_b1 <= cvp_pkg::sat32(65'(head.rz));

			mx_b2     <= {ax[cvp_pkg::NumW-2:0], 16'b0};
			my_b2     <= {ay[cvp_pkg::NumW-2:0], 16'b0};
			zc_b2     <= zc_b1;
			sb_b2.sx  <= nx_b1[cvp_pkg::NumW-1];
			sb_b2.sy  <= ny_b1[cvp_pkg::NumW-1];
			sb_b2.dep <= dep_b1;

			sb_sd[0] <= sb_b2;
			for (int k = 1; k < N; k++) begin
				sb_sd[k] <= sb_sd[k-1];
			end

			qx_b3  <= sb_sd[N-1].sx ? -$signed(65'(qx)) : $signed(65'(qx));
			qy_b3  <= sb_sd[N-1].sy ? -$signed(65'(qy)) : $signed(65'(qy));
			dep_b3 <= sb_sd[N-1].dep;

			sx_q  <= cvp_pkg::sat32(cvp_pkg::SCREEN_X_OFS + qx_b3);
			sy_q  <= cvp_pkg::sat32(cvp_pkg::SCREEN_Y_OFS - qy_b3);
			dep_q <= dep_b3;
		end
	end

	cvp_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (mx_b2),
		.den (zc_b2),
		.quo (qx)
	);

	cvp_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (my_b2),
		.den (zc_b2),
		.quo (qy)
	);

	assign out_valid  = out_valid_q;
	assign screen_x   = sx_q;
	assign screen_y   = sy_q;
	assign view_depth = dep_q;

endmodule

[rtl/core/camera_view_projection.sv]
// perspective projection of Q16.16 world points onto a 1920x1080 screen: camera offset,
// yaw then pitch rotation from software-held Q1.14 sines and cosines, then x and y scaled
// by focal over the depth (clamped to one lsb) around the screen center; one point per
// cycle in and out unless stalled; 5 rotation stages, the queue, 2 setup stages, the
// two restoring dividers of 63 stages, one quotient bit each, then sign and saturation
// stages; the user must write configuration only while no point is in flight (unenforced)
`include "camera_view_projection_macros.svh"

module camera_view_projection (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // point_x, point_y, point_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // screen_x, screen_y, view_depth
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata
);

	cvp_pkg::cvp_cfg_t   cfg_q;
	cvp_pkg::cvp_view_t  front_view, queue_head;
	cvp_pkg::cvp_qstat_t qstat;
	logic push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_x     <= '0;
			cfg_q.cam_y     <= '0;
			cfg_q.cam_z     <= '0;
			cfg_q.cos_yaw   <= 16'sd16384;
			cfg_q.sin_yaw   <= '0;
			cfg_q.cos_pitch <= 16'sd16384;
			cfg_q.sin_pitch <= '0;
			cfg_q.focal     <= 10'd1000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cvp_pkg::REG_CAM_X:     cfg_q.cam_x     <= cfg_wdata;
				cvp_pkg::REG_CAM_Y:     cfg_q.cam_y     <= cfg_wdata;
				cvp_pkg::REG_CAM_Z:     cfg_q.cam_z     <= cfg_wdata;
				cvp_pkg::REG_COS_YAW:   cfg_q.cos_yaw   <= cfg_wdata[15:0];
				cvp_pkg::REG_SIN_YAW:   cfg_q.sin_yaw   <= cfg_wdata[15:0];
				cvp_pkg::REG_COS_PITCH: cfg_q.cos_pitch <= cfg_wdata[15:0];
				cvp_pkg::REG_SIN_PITCH: cfg_q.sin_pitch <= cfg_wdata[15:0];
				cvp_pkg::REG_FOCAL:     cfg_q.focal     <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	cvp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.px       (s_axis_tdata[31:0]),
		.py       (s_axis_tdata[63:32]),
		.pz       (s_axis_tdata[95:64]),
		.q_full   (qstat.full),
		.push     (push),
		.view     (front_view)
	);

	cvp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_view),
		.pop     (pop),
		.rd_data (queue_head),
		.stat    (qstat)
	);

	cvp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.focal      (cfg_q.focal),
		.q_empty    (qstat.empty),
		.head       (queue_head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.screen_x   (m_axis_tdata[31:0]),
		.screen_y   (m_axis_tdata[63:32]),
		.view_depth (m_axis_tdata[95:64])
	);

	`CVP_ASSERT_SAME(a_queue_bound, 1'b1, qstat.cnt <= 3'(cvp_pkg::QueueDepth))
	`CVP_ASSERT_NEXT(a_qcnt, 1'b1, qstat.cnt == $past(qstat.cnt) + 3'($past(push)) - 3'($past(pop)))
	`CVP_ASSERT_SAME(a_push_room, push, !qstat.full)

endmodule

[tb/camera_view_projection_tb.sv]
`timescale 1ns / 100ps

module camera_view_projection_tb;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata;  // point_x, point_y, point_z
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;  // screen_x, screen_y, view_depth
	logic         cfg_we;
	logic [2:0]   cfg_idx;
	logic [31:0]  cfg_wdata;

	camera_view_projection u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
	logic signed [15:0] cos_yaw_r, sin_yaw_r, cos_pitch_r, sin_pitch_r;
	logic [9:0]         focal_r;

	logic [95:0] point_queue[$];
	logic [95:0] projected_queue[$];
	int          error_count;
	bit          steady;
	bit          in_done;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647) begin
			return 32'h7fffffff;
		end else if (v < -128'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [95:0] project_point(logic [95:0] p);
		logic signed [127:0] dx, dy, dz, rx, w, rz, ry, zc, qx, qy, f;
		dx = $signed(p[31:0]) - cam_x_r;
		dy = $signed(p[63:32]) - cam_y_r;
		dz = $signed(p[95:64]) - cam_z_r;
		f = {118'd0, focal_r};
		rx = (dx * cos_yaw_r - dz * sin_yaw_r) >>> 14;
		w  = (dx * sin_yaw_r + dz * cos_yaw_r) >>> 14;
		rz = (w * cos_pitch_r + dy * sin_pitch_r) >>> 14;
		ry = (dy * cos_pitch_r - w * sin_pitch_r) >>> 14;
		zc = (rz < 128'sd1) ? 128'sd1 : rz;
		qx = (rx * f * 128'sd65536) / zc;
		qy = (ry * f * 128'sd65536) / zc;
		return {clamp32(rz), clamp32(128'sd35389440 - qy), clamp32(128'sd62914560 + qx)};
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	// input driver
	always @(negedge clk) begin
		logic nv;
		nv = s_axis_tvalid;
		if (!s_axis_tvalid || in_done) begin
			nv = 1'b0;
			if (point_queue.size() > 0 && (steady || $urandom_range(99) >= 31)) begin
				s_axis_tdata <= point_queue.pop_front();
				nv = 1'b1;
			end
		end
		s_axis_tvalid <= nv;
		m_axis_tready <= steady || $urandom_range(99) >= 31;
	end

	// monitor
	always @(posedge clk) begin
		logic [95:0] want;
		in_done <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			projected_queue.push_back(project_point(s_axis_tdata));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (projected_queue.size() == 0) begin
				$display("unexpected transfer %h", m_axis_tdata);
				error_count++;
			end else begin
				want = projected_queue.pop_front();
				if (m_axis_tdata[31:0] !== want[31:0]) begin
					report("screen_x", m_axis_tdata[31:0], want[31:0]);
				end
				if (m_axis_tdata[63:32] !== want[63:32]) begin
					report("screen_y", m_axis_tdata[63:32], want[63:32]);
				end
				if (m_axis_tdata[95:64] !== want[95:64]) begin
					report("view_depth", m_axis_tdata[95:64], want[95:64]);
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cvp_pkg::REG_CAM_X: cam_x_r = val;
			cvp_pkg::REG_CAM_Y: cam_y_r = val;
			cvp_pkg::REG_CAM_Z: cam_z_r = val;
			cvp_pkg::REG_COS_YAW: cos_yaw_r = val[15:0];
			cvp_pkg::REG_SIN_YAW: sin_yaw_r = val[15:0];
			cvp_pkg::REG_COS_PITCH: cos_pitch_r = val[15:0];
			cvp_pkg::REG_SIN_PITCH: sin_pitch_r = val[15:0];
			cvp_pkg::REG_FOCAL: focal_r = val[9:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [15:0] c_yaw, logic [15:0] s_yaw, logic [15:0] c_pitch,
			logic [15:0] s_pitch, logic [9:0] focal);
		write_reg(cvp_pkg::REG_CAM_X, cx);
		write_reg(cvp_pkg::REG_CAM_Y, cy);
		write_reg(cvp_pkg::REG_CAM_Z, cz);
		write_reg(cvp_pkg::REG_COS_YAW, {{16{c_yaw[15]}}, c_yaw});
		write_reg(cvp_pkg::REG_SIN_YAW, {{16{s_yaw[15]}}, s_yaw});
		write_reg(cvp_pkg::REG_COS_PITCH, {{16{c_pitch[15]}}, c_pitch});
		write_reg(cvp_pkg::REG_SIN_PITCH, {{16{s_pitch[15]}}, s_pitch});
		write_reg(cvp_pkg::REG_FOCAL, {22'd0, focal});
	endtask

	task automatic drain();
		while (point_queue.size() > 0 || projected_queue.size() > 0 || s_axis_tvalid) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] near_value(logic [31:0] center);
		if ($urandom_range(3) == 0) begin
			return $urandom;
		end
		return center + $signed($urandom_range(2097152)) - 32'sd1048576;
	endfunction

	task automatic queue_random(int count);
		logic [31:0] px, py, pz;
		repeat (count) begin
			px = near_value(cam_x_r);
			py = near_value(cam_y_r);
			pz = near_value(cam_z_r);
			if ($urandom_range(1)) begin
				pz = cam_z_r + $urandom_range(2000000, 1);
			end
			point_queue.push_back({pz, py, px});
		end
	endtask

	logic [15:0] trig_pick[5] = '{16'sd16384, -16'sd16384, 16'sd0, -16'sd32768, 16'sd32767};

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		error_count = 0;
		steady = 1'b0;
		in_done = 1'b0;
		cam_x_r = 0;
		cam_y_r = 0;
		cam_z_r = 0;
		cos_yaw_r = 16384;
		sin_yaw_r = 0;
		cos_pitch_r = 16384;
		sin_pitch_r = 0;
		focal_r = 1000;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed points at reset settings
		point_queue.push_back({32'h00010000, 32'h0, 32'h0});
		point_queue.push_back({32'h00640000, 32'h00010000, 32'hffff0000});
		point_queue.push_back({32'h0, 32'h00010000, 32'h00010000});
		point_queue.push_back({32'hffff0000, 32'h00010000, 32'h00010000});
		point_queue.push_back({32'h00000001, 32'h7fffffff, 32'h80000000});
		point_queue.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
		point_queue.push_back({32'h7fffffff, 32'h80000000, 32'h80000000});
		point_queue.push_back({32'h80000000, 32'h7fffffff, 32'h7fffffff});
		point_queue.push_back({32'hffffffff, 32'hffffffff, 32'hffffffff});
		point_queue.push_back({32'h00000002, 32'h00000003, 32'hfffffffd});
		drain();

		// camera at extremes, trig at out-of-range values, focal zero and then 1023
		write_all(32'h7fffffff, 32'h80000000, 32'h80000000, 16'h8000, 16'h7fff,
			16'h8000, 16'h8000, 10'd0);
		point_queue.push_back({32'h7fffffff, 32'h7fffffff, 32'h80000000});
		point_queue.push_back({32'h80000000, 32'h80000000, 32'h7fffffff});
		point_queue.push_back({32'h0, 32'h0, 32'h0});
		drain();
		write_all(32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h8000,
			16'h7fff, 16'h7fff, 10'd1023);
		point_queue.push_back({32'h7fffffff, 32'h80000000, 32'h80000000});
		point_queue.push_back({32'h80000000, 32'h7fffffff, 32'h7fffffff});
		point_queue.push_back({32'h00000000, 32'h12345678, 32'h87654321});
		drain();

		// random settings, back-to-back stretch on one phase
		for (int ph = 0; ph < 10; ph++) begin
			if (ph % 3 == 0) begin
				write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			end else begin
				write_all($urandom_range(20000000) - 10000000,
					$urandom_range(20000000) - 10000000,
					$urandom_range(20000000) - 10000000,
					trig_pick[$urandom_range(4)], trig_pick[$urandom_range(4)],
					trig_pick[$urandom_range(4)], trig_pick[$urandom_range(4)],
					$urandom_range(1000, 100));
			end
			steady = (ph == 4);
			queue_random(150);
			drain();
			steady = 1'b0;
		end
		write_all(0, 0, 0, 16'd16384, 16'd0, 16'd16384, 16'd0, 10'd100);
		queue_random(30);
		drain();

		if (error_count == 0) begin
			$display("camera_view_projection_tb: done, clean");
		end else begin
			$display("camera_view_projection_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("camera_view_projection_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/cvp_pkg.sv
rtl/core/cvp_front.sv
rtl/core/cvp_queue.sv
rtl/core/cvp_div.sv
rtl/core/cvp_back.sv
rtl/core/camera_view_projection.sv
tb/camera_view_projection_tb.sv
